// ===== hdl/cossim_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package cossim_pkg;

    localparam int ELEM_W = 16;
    localparam int PROD_W = 32;
    localparam int ROOT_W = 17;

    typedef enum logic [5:0] {
        ST_ACC   = 6'b000001,
        ST_SETUP = 6'b000010,
        ST_PROD  = 6'b000100,
        ST_ROOT  = 6'b001000,
        ST_OUT   = 6'b010000,
        ST_WAIT  = 6'b100000
    } cs_state_t;

    typedef struct packed {
        logic acc_en;
        logic clear;
        logic setup;
        logic prod_step;
        logic root_start;
        logic root_step;
        logic load_out;
    } cs_cmd_t;

    typedef struct packed {
        logic prod_done;
        logic root_done;
    } cs_stat_t;

endpackage
`default_nettype wire

// ===== hdl/cossim_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module cossim_datapath #(
    parameter int SUM_W = 42,
    parameter int CNT_W = 11,
    parameter int MAX_LEN = 1024
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire cossim_pkg::cs_cmd_t  cmd,
    output cossim_pkg::cs_stat_t      stat,
    input  wire logic signed [15:0]   elem_a,
    input  wire logic signed [15:0]   elem_b,
    input  wire logic signed [15:0]   threshold,
    output logic signed [15:0]        sim_out,
    output logic                      above_out,
    output logic                      zero_out,
    output logic                      long_out
);
    import cossim_pkg::*;

    // rhs = dot^2 << 32, lhs = (2k-1)^2 * na * nb ; all sized to hold worst case
    localparam int N_W   = SUM_W - 1;
    localparam int P_W   = 2 * N_W;
    localparam int RHS_W = 2 * N_W + 32;
    localparam int LHS_W = P_W + 2 * ROOT_W;
    localparam int CMP_W = (LHS_W > RHS_W) ? LHS_W : RHS_W;
    localparam int PC_W  = $clog2(N_W + 1);

    logic signed [SUM_W-1:0] dot_reg;
    logic [N_W-1:0]          na_reg, nb_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    ovf_reg;

    logic signed [PROD_W-1:0] pab, paa, pbb;
    assign pab = elem_a * elem_b;
    assign paa = elem_a * elem_a;
    assign pbb = elem_b * elem_b;

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            dot_reg <= '0;
            na_reg  <= '0;
            nb_reg  <= '0;
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
        end else if (cmd.acc_en) begin
            if (cnt_reg >= CNT_W'(MAX_LEN)) begin
                ovf_reg <= 1'b1;
            end else begin
                dot_reg <= dot_reg + SUM_W'(pab);
                na_reg  <= na_reg + N_W'($unsigned(paa));
                nb_reg  <= nb_reg + N_W'($unsigned(pbb));
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // shift-add products: prod = na*nb, rhs = mag^2 (one bit per cycle)
    logic [N_W-1:0]   mulb_reg, mulb2_reg;
    logic [P_W-1:0]   prod_reg, rhs_reg, sha_reg, shm_reg;
    logic [PC_W-1:0]  pcnt_reg;
    logic             zero_reg, neg_reg, long_reg;

    always_ff @(posedge aclk) begin
        if (cmd.setup) begin
            neg_reg   <= dot_reg[SUM_W-1];
            zero_reg  <= (na_reg == '0) || (nb_reg == '0);
            long_reg  <= ovf_reg;
            sha_reg   <= P_W'(na_reg);
            mulb_reg  <= nb_reg;
            shm_reg   <= dot_reg[SUM_W-1] ? P_W'(N_W'(-dot_reg)) : P_W'(N_W'(dot_reg));
            mulb2_reg <= dot_reg[SUM_W-1] ? N_W'(-dot_reg) : N_W'(dot_reg);
            prod_reg  <= '0;
            rhs_reg   <= '0;
            pcnt_reg  <= '0;
        end else if (cmd.prod_step) begin
            if (mulb_reg[0])  prod_reg <= prod_reg + sha_reg;
            if (mulb2_reg[0]) rhs_reg  <= rhs_reg + shm_reg;
            sha_reg   <= sha_reg << 1;
            shm_reg   <= shm_reg << 1;
            mulb_reg  <= mulb_reg >> 1;
            mulb2_reg <= mulb2_reg >> 1;
            pcnt_reg  <= pcnt_reg + 1'b1;
        end
    end
    assign stat.prod_done = (pcnt_reg == PC_W'(N_W));

    // bit-by-bit search for largest k: (2k-1)^2 * prod <= rhs<<32.
    // (2k-1)^2 = 4k^2 - 4k + 1; trial evaluated by shift-add across one bit per cycle
    logic [ROOT_W-1:0] k_reg;
    logic [4:0]        bit_reg;
    logic [ROOT_W-1:0] trial;
    logic [ROOT_W-1:0] odd;
    logic [2*ROOT_W-1:0] odd_sq;
    logic [CMP_W-1:0]  lhs, rhs_full;

    assign trial  = k_reg | (ROOT_W'(1) << bit_reg);
    // trial never exceeds 32768 when used, so 2*trial-1 fits in ROOT_W bits
    assign odd    = ROOT_W'({trial, 1'b0} - 1'b1);
    assign odd_sq = (2 * ROOT_W)'(odd) * (2 * ROOT_W)'(odd);

    // multiply odd_sq by prod, bit-serially by shift-add
    logic [CMP_W-1:0]      acc_reg, addend_reg;
    logic [2*ROOT_W-1:0]   mult_reg;
    logic [5:0]            mcnt_reg;
    logic                  mbusy_reg;

    assign rhs_full = CMP_W'(rhs_reg) << 32;
    assign lhs      = acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mbusy_reg <= 1'b0;
        end else if (cmd.root_start) begin
            k_reg     <= '0;
            bit_reg   <= 5'(ROOT_W - 1);
            mbusy_reg <= 1'b0;
        end else if (cmd.root_step) begin
            if (!mbusy_reg) begin
                if (trial > ROOT_W'(32768)) begin
                    bit_reg <= bit_reg - 1'b1;
                end else begin
                    acc_reg    <= '0;
                    addend_reg <= CMP_W'(prod_reg);
                    mult_reg   <= odd_sq;
                    mcnt_reg   <= '0;
                    mbusy_reg  <= 1'b1;
                end
            end else if (mcnt_reg != 6'(2 * ROOT_W)) begin
                if (mult_reg[0]) acc_reg <= acc_reg + addend_reg;
                addend_reg <= addend_reg << 1;
                mult_reg   <= mult_reg >> 1;
                mcnt_reg   <= mcnt_reg + 1'b1;
            end else begin
                if (lhs <= rhs_full) k_reg <= trial;
                bit_reg   <= bit_reg - 1'b1;
                mbusy_reg <= 1'b0;
            end
        end
    end
    assign stat.root_done = (bit_reg == 5'd31) && !mbusy_reg;

    logic signed [15:0] sim_val;
    always_comb begin
        if (zero_reg)       sim_val = '0;
        else if (neg_reg)   sim_val = 16'(-$signed({1'b0, k_reg}));
        else if (k_reg > ROOT_W'(32767)) sim_val = 16'sd32767;
        else                sim_val = 16'(k_reg);
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            sim_out   <= sim_val;
            above_out <= sim_val > threshold;
            zero_out  <= zero_reg;
            long_out  <= long_reg;
        end
    end
endmodule
`default_nettype wire

// ===== hdl/cossim_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module cossim_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic                 s_last,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    input  wire cossim_pkg::cs_stat_t stat,
    output cossim_pkg::cs_cmd_t       cmd
);
    import cossim_pkg::*;

    cs_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_ACC;
        else          state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        unique case (state_reg)
            ST_ACC: begin
                s_ready    = 1'b1;
                cmd.acc_en = s_valid;
                if (s_valid && s_last) state_next = ST_SETUP;
            end
            ST_SETUP: begin
                cmd.setup  = 1'b1;
                state_next = ST_PROD;
            end
            ST_PROD: begin
                cmd.prod_step = 1'b1;
                if (stat.prod_done) begin
                    cmd.prod_step  = 1'b0;
                    cmd.root_start = 1'b1;
                    cmd.clear      = 1'b1;
                    state_next     = ST_ROOT;
                end
            end
            ST_ROOT: begin
                cmd.root_step = 1'b1;
                if (stat.root_done) begin
                    cmd.root_step = 1'b0;
                    cmd.load_out  = 1'b1;
                    state_next    = ST_OUT;
                end
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) state_next = ST_ACC;
            end
            ST_WAIT: state_next = ST_ACC;
            default: state_next = ST_ACC;
        endcase
    end
endmodule
`default_nettype wire

// ===== hdl/cosine_similarity.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel | ports                                   | dir
// s_      | s_valid s_ready s_elem_a s_elem_b s_last| in
// m_      | m_valid m_ready m_similarity + 3 flags  | out
// cfg     | cfg_valid cfg_ready cfg_data            | in
//
// Element pairs: one per cycle while s_ready is high, accumulated
// with three 16x16 products. On last: shift-add products, then a
// 17-bit search with a shift-add multiply per bit. Reset clears sums
// and loads threshold 31130. Input stalls until the result beat is
// taken.
module cosine_similarity #(
    parameter int MAX_LEN = 1024
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [15:0] s_elem_a,
    input  wire logic signed [15:0] s_elem_b,
    input  wire logic               s_last,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [15:0]      m_similarity,
    output logic                    m_above_threshold,
    output logic                    m_zero_norm,
    output logic                    m_too_long,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic signed [15:0] cfg_data
);
    import cossim_pkg::*;

    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam int SUM_W = 32 + $clog2(MAX_LEN + 1);

    cs_cmd_t  cmd;
    cs_stat_t stat;
    logic signed [15:0] thr_reg;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn)       thr_reg <= 16'sd31130;
        else if (cfg_valid) thr_reg <= cfg_data;
    end

    cossim_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_last,
        .m_valid, .m_ready, .stat, .cmd
    );

    cossim_datapath #(.SUM_W(SUM_W), .CNT_W(CNT_W), .MAX_LEN(MAX_LEN)) u_dp (
        .aclk, .aresetn, .cmd, .stat,
        .elem_a(s_elem_a), .elem_b(s_elem_b), .threshold(thr_reg),
        .sim_out(m_similarity), .above_out(m_above_threshold),
        .zero_out(m_zero_norm), .long_out(m_too_long)
    );

    a_no_in_when_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input open while result pending");
    a_zero_sim: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_zero_norm) |-> (m_similarity == 16'sd0)) else $error("zero norm sim");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(m_similarity)) else $error("result changed");
endmodule
`default_nettype wire
